### rtl/core/mrc_pkg.sv
package mrc_pkg;

  // fixed field widths and dimension count
  localparam int FLAT_BITS    = 48;
  localparam int NUM_DIMS     = 4;

  // restoring division: quotient bits resolved per pipeline stage
  localparam int DIV_STEPS    = 4;
  localparam int DIV_STAGES   = FLAT_BITS / DIV_STEPS;

  // saturation value for strides and the total size
  localparam logic [FLAT_BITS:0] STRIDE_CAP = {1'b1, {FLAT_BITS{1'b0}}};

  // conversion direction
  localparam logic FUNC_LIN   = 1'b0;
  localparam logic FUNC_DELIN = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 3;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SIZE_DIM0 = 3'd0,
    CFG_SIZE_DIM1 = 3'd1,
    CFG_SIZE_DIM2 = 3'd2,
    CFG_SIZE_DIM3 = 3'd3
  } cfg_idx_t;

  // control that travels with each beat down the pipeline
  typedef struct packed {
    logic vld;
    logic func;
    logic oor;
  } mrc_ctl_t;

endpackage

### rtl/core/mrc_lin_dim.sv
module mrc_lin_dim
  import mrc_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int DIM        = 0
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mrc_ctl_t                             ctl_i,
  input  logic [FLAT_BITS-1:0]                 flat_i,
  input  logic [NUM_DIMS-1:0][COORD_BITS-1:0]  coord_i,
  input  logic [FLAT_BITS:0]                   stride_i,
  input  logic [COORD_BITS:0]                  size_i,
  output mrc_ctl_t                             ctl_o,
  output logic [FLAT_BITS-1:0]                 flat_o,
  output logic [NUM_DIMS-1:0][COORD_BITS-1:0]  coord_o,
  output logic [FLAT_BITS:0]                   stride_o
);

  localparam int TERM_W = FLAT_BITS + 1 + COORD_BITS;
  localparam int PROD_W = FLAT_BITS + 2 + COORD_BITS;

  mrc_ctl_t                            ctl_a_r;
  logic [FLAT_BITS-1:0]                flat_a_r;
  logic [NUM_DIMS-1:0][COORD_BITS-1:0] coord_a_r;
  logic [FLAT_BITS-1:0]                term_a_r;
  logic [PROD_W-1:0]                   sprod_a_r;
  logic [TERM_W-1:0]                   term_full;
  logic [FLAT_BITS-1:0]                term_a_nxt;
  logic [PROD_W-1:0]                   sprod_a_nxt;

  mrc_ctl_t                            ctl_b_r;
  logic [FLAT_BITS-1:0]                flat_b_r;
  logic [NUM_DIMS-1:0][COORD_BITS-1:0] coord_b_r;
  logic [FLAT_BITS:0]                  stride_b_r;
  logic [FLAT_BITS-1:0]                flat_b_nxt;
  logic [FLAT_BITS:0]                  stride_b_nxt;

  // stage a: coordinate times stride, and the next stride before saturation
  always_comb begin
    term_full   = TERM_W'(coord_i[DIM]) * TERM_W'(stride_i);
    term_a_nxt  = term_full[FLAT_BITS-1:0];
    sprod_a_nxt = PROD_W'(stride_i) * PROD_W'(size_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
    end else begin
      ctl_a_r <= ctl_i;
    end
    flat_a_r  <= flat_i;
    coord_a_r <= coord_i;
    term_a_r  <= term_a_nxt;
    sprod_a_r <= sprod_a_nxt;
  end

  // stage b: accumulate the term, saturate the stride
  always_comb begin
    if (ctl_a_r.func == FUNC_LIN) begin
      flat_b_nxt = flat_a_r + term_a_r;
    end else begin
      flat_b_nxt = flat_a_r;
    end
    if (sprod_a_r > PROD_W'(STRIDE_CAP)) begin
      stride_b_nxt = STRIDE_CAP;
    end else begin
      stride_b_nxt = sprod_a_r[FLAT_BITS:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_b_r <= '0;
    end else begin
      ctl_b_r <= ctl_a_r;
    end
    flat_b_r   <= flat_b_nxt;
    coord_b_r  <= coord_a_r;
    stride_b_r <= stride_b_nxt;
  end

  assign ctl_o    = ctl_b_r;
  assign flat_o   = flat_b_r;
  assign coord_o  = coord_b_r;
  assign stride_o = stride_b_r;

`ifndef ASSERT_OFF
  // a split request keeps its flat index untouched through the accumulator
  a_delin_passes: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_o.vld && ctl_o.func == FUNC_DELIN) |-> flat_o == $past(flat_i, 2))
    else $error("flat index altered in linearise stage");
`endif

endmodule

### rtl/core/mrc_div_dim.sv
module mrc_div_dim
  import mrc_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int DIM        = 0
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mrc_ctl_t                             ctl_i,
  input  logic [FLAT_BITS-1:0]                 flat_i,
  input  logic [NUM_DIMS-1:0][COORD_BITS-1:0]  coord_i,
  input  logic [COORD_BITS:0]                  size_i,
  output mrc_ctl_t                             ctl_o,
  output logic [FLAT_BITS-1:0]                 flat_o,
  output logic [NUM_DIMS-1:0][COORD_BITS-1:0]  coord_o
);

  mrc_ctl_t                            ctl_r   [DIV_STAGES];
  logic [FLAT_BITS-1:0]                flat_r  [DIV_STAGES];
  logic [NUM_DIMS-1:0][COORD_BITS-1:0] coord_r [DIV_STAGES];
  logic [COORD_BITS-1:0]               rem_r   [DIV_STAGES-1];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    mrc_ctl_t                            ctl_in;
    logic [FLAT_BITS-1:0]                num_in;
    logic [COORD_BITS-1:0]               rem_in;
    logic [NUM_DIMS-1:0][COORD_BITS-1:0] coord_in;
    logic [FLAT_BITS-1:0]                num_nxt;
    logic [COORD_BITS-1:0]               rem_nxt;
    logic [NUM_DIMS-1:0][COORD_BITS-1:0] coord_nxt;

    // stage inputs: the remainder starts at zero for each dimension
    if (s == 0) begin : g_first
      assign ctl_in   = ctl_i;
      assign num_in   = flat_i;
      assign rem_in   = '0;
      assign coord_in = coord_i;
    end else begin : g_next
      assign ctl_in   = ctl_r[s-1];
      assign num_in   = flat_r[s-1];
      assign rem_in   = rem_r[s-1];
      assign coord_in = coord_r[s-1];
    end

    // DIV_STEPS restoring division steps, quotient bits shift in at the bottom
    always_comb begin
      logic [COORD_BITS:0]   part;
      logic [COORD_BITS-1:0] rem_v;
      logic [FLAT_BITS-1:0]  num_v;
      rem_v = rem_in;
      num_v = num_in;
      for (int k = 0; k < DIV_STEPS; k++) begin
        part = {rem_v, num_v[FLAT_BITS-1]};
        if (part >= size_i) begin
          rem_v = COORD_BITS'(part - size_i);
          num_v = {num_v[FLAT_BITS-2:0], 1'b1};
        end else begin
          rem_v = part[COORD_BITS-1:0];
          num_v = {num_v[FLAT_BITS-2:0], 1'b0};
        end
      end
      coord_nxt = coord_in;
      if (ctl_in.func == FUNC_DELIN) begin
        num_nxt = num_v;
        rem_nxt = rem_v;
        if (s == DIV_STAGES - 1) begin
          coord_nxt[DIM] = rem_v;
        end
      end else begin
        num_nxt = num_in;
        rem_nxt = rem_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[s] <= '0;
      end else begin
        ctl_r[s] <= ctl_in;
      end
      flat_r[s]  <= num_nxt;
      coord_r[s] <= coord_nxt;
    end

    // partial remainder carried between stages of the same dimension
    if (s < DIV_STAGES - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem_r[s] <= rem_nxt;
      end
    end
  end

  assign ctl_o   = ctl_r[DIV_STAGES-1];
  assign flat_o  = flat_r[DIV_STAGES-1];
  assign coord_o = coord_r[DIV_STAGES-1];

`ifndef ASSERT_OFF
  // a linearise result rides through the divider unchanged
  a_lin_passes: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_o.vld && ctl_o.func == FUNC_LIN) |-> flat_o == $past(flat_i, DIV_STAGES))
    else $error("linear index altered in divider stage");
`endif

endmodule

### rtl/core/mixed_radix_index_convert_unit.sv
// Mixed-radix index converter. With in_func 0 the four coordinates are joined
// into a flat index (dimension 0 least significant, stride of each dimension
// the product of the lower sizes); with in_func 1 the flat index is split back
// into coordinates. out_out_of_range flags a coordinate not below its size or
// a flat index not below the total size; the result is still computed. A new
// beat is taken on every clock (busy stays low) and each result appears on the
// out_ ports for one cycle with out_valid, in order; the receiver cannot
// stall it. In the divider each dimension takes 12 stages of 4 restoring
// steps for the 48-bit quotient, after one input stage, two stages per
// dimension of multiply and accumulate and one range check stage; one output
// stage follows. The user must write size registers through cfg_ (always
// ready) only while no beat is in flight; the block does not enforce this. A
// size of zero reads as one and a size above 2^COORD_BITS as 2^COORD_BITS.
module mixed_radix_index_convert_unit
  import mrc_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_func,
  input  logic [FLAT_BITS-1:0]    in_flat_in,
  input  logic [COORD_BITS-1:0]   in_coord_in0,
  input  logic [COORD_BITS-1:0]   in_coord_in1,
  input  logic [COORD_BITS-1:0]   in_coord_in2,
  input  logic [COORD_BITS-1:0]   in_coord_in3,
  output logic                    out_valid,
  output logic [FLAT_BITS-1:0]    out_flat_out,
  output logic [COORD_BITS-1:0]   out_coord_out0,
  output logic [COORD_BITS-1:0]   out_coord_out1,
  output logic [COORD_BITS-1:0]   out_coord_out2,
  output logic [COORD_BITS-1:0]   out_coord_out3,
  output logic                    out_out_of_range,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS:0]     cfg_data
);

  logic [COORD_BITS:0]                 size_r [NUM_DIMS];
  logic [COORD_BITS:0]                 size_nxt;

  logic [NUM_DIMS-1:0][COORD_BITS-1:0] coord_in_w;
  logic                                oor_lin;
  mrc_ctl_t                            in_ctl_r;
  mrc_ctl_t                            in_ctl_nxt;
  logic [FLAT_BITS-1:0]                in_flat_r;
  logic [FLAT_BITS-1:0]                in_flat_nxt;
  logic [NUM_DIMS-1:0][COORD_BITS-1:0] in_coord_r;
  logic [NUM_DIMS-1:0][COORD_BITS-1:0] in_coord_nxt;

  mrc_ctl_t                            lin_ctl    [NUM_DIMS+1];
  logic [FLAT_BITS-1:0]                lin_flat   [NUM_DIMS+1];
  logic [NUM_DIMS-1:0][COORD_BITS-1:0] lin_coord  [NUM_DIMS+1];
  logic [FLAT_BITS:0]                  lin_stride [NUM_DIMS+1];

  mrc_ctl_t                            mid_ctl_r;
  mrc_ctl_t                            mid_ctl_nxt;
  logic [FLAT_BITS-1:0]                mid_flat_r;
  logic [NUM_DIMS-1:0][COORD_BITS-1:0] mid_coord_r;

  mrc_ctl_t                            div_ctl   [NUM_DIMS+1];
  logic [FLAT_BITS-1:0]                div_flat  [NUM_DIMS+1];
  logic [NUM_DIMS-1:0][COORD_BITS-1:0] div_coord [NUM_DIMS+1];

  logic                                out_valid_r;
  logic [FLAT_BITS-1:0]                out_flat_r;
  logic [FLAT_BITS-1:0]                out_flat_nxt;
  logic [NUM_DIMS-1:0][COORD_BITS-1:0] out_coord_r;
  logic [NUM_DIMS-1:0][COORD_BITS-1:0] out_coord_nxt;
  logic                                out_oor_r;

  // the pipeline never stalls
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // size register clamp: zero reads as one, above the cap reads as the cap
  always_comb begin
    if (cfg_data[COORD_BITS]) begin
      size_nxt = {1'b1, {COORD_BITS{1'b0}}};
    end else if (cfg_data == '0) begin
      size_nxt = (COORD_BITS+1)'(1);
    end else begin
      size_nxt = cfg_data;
    end
  end

  // size register writes, indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < NUM_DIMS; d++) begin
        size_r[d] <= (COORD_BITS+1)'(1);
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SIZE_DIM0: size_r[0] <= size_nxt;
        CFG_SIZE_DIM1: size_r[1] <= size_nxt;
        CFG_SIZE_DIM2: size_r[2] <= size_nxt;
        CFG_SIZE_DIM3: size_r[3] <= size_nxt;
        default: ;
      endcase
    end
  end

  // input stage: coordinate range check, unused payload cleared
  assign coord_in_w[0] = in_coord_in0;
  assign coord_in_w[1] = in_coord_in1;
  assign coord_in_w[2] = in_coord_in2;
  assign coord_in_w[3] = in_coord_in3;

  always_comb begin
    oor_lin = 1'b0;
    for (int d = 0; d < NUM_DIMS; d++) begin
      if ((COORD_BITS+1)'(coord_in_w[d]) >= size_r[d]) begin
        oor_lin = 1'b1;
      end
    end
    in_ctl_nxt.vld  = start && !busy;
    in_ctl_nxt.func = in_func;
    if (in_func == FUNC_LIN) begin
      in_ctl_nxt.oor = oor_lin;
      in_flat_nxt    = '0;
      in_coord_nxt   = coord_in_w;
    end else begin
      in_ctl_nxt.oor = 1'b0;
      in_flat_nxt    = in_flat_in;
      in_coord_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_ctl_r <= '0;
    end else begin
      in_ctl_r <= in_ctl_nxt;
    end
    in_flat_r  <= in_flat_nxt;
    in_coord_r <= in_coord_nxt;
  end

  // multiply and accumulate chain, strides built alongside
  assign lin_ctl[0]    = in_ctl_r;
  assign lin_flat[0]   = in_flat_r;
  assign lin_coord[0]  = in_coord_r;
  assign lin_stride[0] = (FLAT_BITS+1)'(1);

  for (genvar d = 0; d < NUM_DIMS; d++) begin : g_lin
    mrc_lin_dim #(
      .COORD_BITS (COORD_BITS),
      .DIM        (d)
    ) u_lin (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl_i    (lin_ctl[d]),
      .flat_i   (lin_flat[d]),
      .coord_i  (lin_coord[d]),
      .stride_i (lin_stride[d]),
      .size_i   (size_r[d]),
      .ctl_o    (lin_ctl[d+1]),
      .flat_o   (lin_flat[d+1]),
      .coord_o  (lin_coord[d+1]),
      .stride_o (lin_stride[d+1])
    );
  end

  // range check of a flat index against the saturated total size
  always_comb begin
    mid_ctl_nxt = lin_ctl[NUM_DIMS];
    if (lin_ctl[NUM_DIMS].func == FUNC_DELIN &&
        {1'b0, lin_flat[NUM_DIMS]} >= lin_stride[NUM_DIMS]) begin
      mid_ctl_nxt.oor = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_ctl_r <= '0;
    end else begin
      mid_ctl_r <= mid_ctl_nxt;
    end
    mid_flat_r  <= lin_flat[NUM_DIMS];
    mid_coord_r <= lin_coord[NUM_DIMS];
  end

  // successive division, one dimension at a time
  assign div_ctl[0]   = mid_ctl_r;
  assign div_flat[0]  = mid_flat_r;
  assign div_coord[0] = mid_coord_r;

  for (genvar d = 0; d < NUM_DIMS; d++) begin : g_div
    mrc_div_dim #(
      .COORD_BITS (COORD_BITS),
      .DIM        (d)
    ) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_i   (div_ctl[d]),
      .flat_i  (div_flat[d]),
      .coord_i (div_coord[d]),
      .size_i  (size_r[d]),
      .ctl_o   (div_ctl[d+1]),
      .flat_o  (div_flat[d+1]),
      .coord_o (div_coord[d+1])
    );
  end

  // output register: the field not asked for reads as zero
  always_comb begin
    if (div_ctl[NUM_DIMS].func == FUNC_LIN) begin
      out_flat_nxt  = div_flat[NUM_DIMS];
      out_coord_nxt = '0;
    end else begin
      out_flat_nxt  = '0;
      out_coord_nxt = div_coord[NUM_DIMS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= div_ctl[NUM_DIMS].vld;
    end
    out_flat_r  <= out_flat_nxt;
    out_coord_r <= out_coord_nxt;
    out_oor_r   <= div_ctl[NUM_DIMS].oor;
  end

  assign out_valid        = out_valid_r;
  assign out_flat_out     = out_flat_r;
  assign out_coord_out0   = out_coord_r[0];
  assign out_coord_out1   = out_coord_r[1];
  assign out_coord_out2   = out_coord_r[2];
  assign out_coord_out3   = out_coord_r[3];
  assign out_out_of_range = out_oor_r;

`ifndef ASSERT_OFF
  // a result carries either a flat index or coordinates, never both
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_flat_out != '0) |->
      (out_coord_out0 == '0 && out_coord_out1 == '0 &&
       out_coord_out2 == '0 && out_coord_out3 == '0))
    else $error("result carries both flat index and coordinates");
`endif

endmodule
